>>> rtl/iut_pkg.sv
`timescale 1ns / 1ps

package iut_pkg;

  localparam int MAX_INTERVALS = 64;
  localparam int ADDR_BITS     = 32;
  localparam int IDX_BITS      = $clog2(MAX_INTERVALS);
  localparam int CNT_BITS      = $clog2(MAX_INTERVALS + 1);
  localparam int END_BITS      = ADDR_BITS + 1;
  localparam int FIELD_BITS    = 32;
  localparam int OUT_BITS      = 33;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [END_BITS-1:0]  end_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] range_low;
    logic [FIELD_BITS-1:0] range_high;
    logic                  restart;
  } in_word_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] lowest_free;
    logic [OUT_BITS-1:0] free_count;
    logic                table_full;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic prime;
    logic scan;
    logic flush;
    logic result;
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
  } dp_sts_t;

endpackage

>>> rtl/iut_ctrl.sv
`timescale 1ns / 1ps

module iut_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  iut_pkg::dp_sts_t  sts_i,
  output iut_pkg::ctl_cmd_t cmd_o,
  output logic              busy_o
);
  import iut_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PRIME  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_DRAIN1 = 3'd4;
  localparam logic [2:0] S_DRAIN2 = 3'd5;
  localparam logic [2:0] S_RES    = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd_o.prime = 1'b1;
        state_d     = sts_i.cnt_zero ? S_FLUSH : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = S_DRAIN1;
      end
      S_DRAIN1: state_d = S_DRAIN2;
      S_DRAIN2: state_d = S_RES;
      S_RES: begin
        cmd_o.result = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> rtl/iut_datapath.sv
`timescale 1ns / 1ps

module iut_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  iut_pkg::ctl_cmd_t            cmd_i,
  input  iut_pkg::in_word_t            in_word_i,
  input  logic                         cfg_we_i,
  input  logic [iut_pkg::FIELD_BITS-1:0] cfg_wdata_i,
  output iut_pkg::dp_sts_t             sts_o,
  output iut_pkg::out_word_t           out_word_o,
  output logic                         out_valid_o
);
  import iut_pkg::*;

  localparam logic [1:0] MODE_MERGE = 2'd0;
  localparam logic [1:0] MODE_CARRY = 2'd1;
  localparam logic [1:0] MODE_PASS  = 2'd2;

  addr_t mem_s [MAX_INTERVALS];
  end_t  mem_e [MAX_INTERVALS];

  addr_t     max_q, lo_q, ps_q, ps_d, rs_q, cs_q, fs_q, in_lo, in_hi;
  end_t      end_q, pe_q, pe_d, re_q, ce_q, fe_q, contrib_q, cov_q, limit, lowest;
  end_t      wee, clip;
  addr_t     ws;
  cnt_t      cnt_q, rd_idx_q, wr_idx_q;
  logic [1:0] mode_q, mode_d;
  logic      merged_q, merged_d, drop_q, drop_d, cv_q, fv_q;
  logic      we, full, e_before, e_overlap;
  out_word_t out_q;
  logic      out_valid_q;

  assign in_lo = ADDR_BITS'({32'd0, in_word_i.range_low});
  assign in_hi = ADDR_BITS'({32'd0, in_word_i.range_high});
  assign limit = END_BITS'(max_q) + END_BITS'(1);
  assign full  = (cnt_q == CNT_BITS'(MAX_INTERVALS));
  assign e_before  = re_q < END_BITS'(lo_q);
  assign e_overlap = END_BITS'(rs_q) <= end_q;

  always_comb begin
    we       = 1'b0;
    ws       = rs_q;
    wee      = re_q;
    ps_d     = ps_q;
    pe_d     = pe_q;
    mode_d   = mode_q;
    merged_d = merged_q;
    drop_d   = drop_q;
    if (cmd_i.scan) begin
      case (mode_q)
        MODE_MERGE: begin
          if (e_before) begin
            we = 1'b1;
          end else if (e_overlap) begin
            ps_d     = (rs_q < ps_q) ? rs_q : ps_q;
            pe_d     = (re_q > pe_q) ? re_q : pe_q;
            merged_d = 1'b1;
          end else if (!merged_q && full) begin
            drop_d = 1'b1;
            mode_d = MODE_PASS;
            we     = 1'b1;
          end else begin
            we     = 1'b1;
            ws     = ps_q;
            wee    = pe_q;
            ps_d   = rs_q;
            pe_d   = re_q;
            mode_d = MODE_CARRY;
          end
        end
        MODE_CARRY: begin
          we   = 1'b1;
          ws   = ps_q;
          wee  = pe_q;
          ps_d = rs_q;
          pe_d = re_q;
        end
        MODE_PASS: we = 1'b1;
        default: we = 1'b0;
      endcase
    end else if (cmd_i.flush) begin
      ws  = ps_q;
      wee = pe_q;
      case (mode_q)
        MODE_MERGE: begin
          if (!merged_q && full) begin
            drop_d = 1'b1;
          end else begin
            we = 1'b1;
          end
        end
        MODE_CARRY: we = 1'b1;
        default: we = 1'b0;
      endcase
    end
  end

  // table storage, read-first
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_s[wr_idx_q[IDX_BITS-1:0]] <= ws;
      mem_e[wr_idx_q[IDX_BITS-1:0]] <= wee;
    end
    if (cmd_i.prime || cmd_i.scan) begin
      rs_q <= mem_s[rd_idx_q[IDX_BITS-1:0]];
      re_q <= mem_e[rd_idx_q[IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= ADDR_BITS'(64'hFFFF_FFFF);
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      mode_q      <= MODE_PASS;
      merged_q    <= 1'b0;
      drop_q      <= 1'b0;
      cv_q        <= 1'b0;
      fv_q        <= 1'b0;
      contrib_q   <= '0;
      cov_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= ADDR_BITS'({32'd0, cfg_wdata_i});
      end
      out_valid_q <= cmd_i.result;
      if (cmd_i.load) begin
        if (in_word_i.restart) begin
          cnt_q <= '0;
        end
        mode_q    <= (in_hi >= in_lo) ? MODE_MERGE : MODE_PASS;
        merged_q  <= 1'b0;
        drop_q    <= 1'b0;
        rd_idx_q  <= '0;
        wr_idx_q  <= '0;
        cv_q      <= 1'b0;
        fv_q      <= 1'b0;
        contrib_q <= '0;
        cov_q     <= '0;
      end else begin
        mode_q   <= mode_d;
        merged_q <= merged_d;
        drop_q   <= drop_d;
        if (cmd_i.prime || cmd_i.scan) begin
          rd_idx_q <= rd_idx_q + CNT_BITS'(1);
        end
        if (we) begin
          wr_idx_q <= wr_idx_q + CNT_BITS'(1);
        end
        if (cmd_i.flush) begin
          cnt_q <= wr_idx_q + CNT_BITS'(we);
        end
        if (we && (wr_idx_q == '0)) begin
          fv_q <= 1'b1;
        end
        cv_q      <= we;
        contrib_q <= (cv_q && (END_BITS'(cs_q) < limit)) ? (clip - END_BITS'(cs_q)) : '0;
        cov_q     <= cov_q + contrib_q;
      end
    end
  end

  assign clip = (ce_q < limit) ? ce_q : limit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lo_q  <= in_lo;
      end_q <= END_BITS'(in_hi) + END_BITS'(1);
      ps_q  <= in_lo;
      pe_q  <= END_BITS'(in_hi) + END_BITS'(1);
    end else begin
      ps_q <= ps_d;
      pe_q <= pe_d;
    end
    if (we) begin
      cs_q <= ws;
      ce_q <= wee;
    end
    if (we && (wr_idx_q == '0)) begin
      fs_q <= ws;
      fe_q <= wee;
    end
    if (cmd_i.result) begin
      out_q.lowest_free <= OUT_BITS'(lowest);
      out_q.free_count  <= OUT_BITS'(limit - cov_q);
      out_q.table_full  <= drop_q;
    end
  end

  assign lowest = (fv_q && (fs_q == '0)) ? ((fe_q < limit) ? fe_q : limit) : '0;

  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.scan_last = (rd_idx_q == cnt_q);
  assign out_word_o      = out_q;
  assign out_valid_o     = out_valid_q;

endmodule

>>> rtl/interval_union_table_top.sv
// sequence: an accepted word steps through PRIME, SCAN over the stored intervals
// (skipped when the table is empty, as on restart), FLUSH, DRAIN1, DRAIN2 and RES;
// the result strobe is registered from RES; no new word is taken while busy is high
// busy is high from acceptance, low in the strobe cycle; the receiver cannot stall
// reset: asynchronous active low, empties the table and sets max_address to all ones
`timescale 1ns / 1ps

module interval_union_table_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  iut_pkg::in_word_t              in_word_i,
  input  logic                           cfg_we_i,
  input  logic [iut_pkg::FIELD_BITS-1:0] cfg_wdata_i,
  output iut_pkg::out_word_t             out_word_o,
  output logic                           result_valid_o
);
  import iut_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  iut_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  iut_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_o       (sts),
    .out_word_o  (out_word_o),
    .out_valid_o (result_valid_o)
  );

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd)) else $error("more than one datapath command");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  a_strobe_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy && $past(busy))) else $error("strobe outside item end");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("repeated result strobe");

endmodule

>>> verif/interval_union_checker.sv
`timescale 1ns / 1ps

module interval_union_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           busy,
  input  iut_pkg::in_word_t              in_word_i,
  input  logic                           cfg_we_i,
  input  logic [iut_pkg::FIELD_BITS-1:0] cfg_wdata_i,
  input  iut_pkg::out_word_t             out_word_o,
  input  logic                           result_valid_o,
  output int                             pending_o,
  output int                             errors_o
);
  import iut_pkg::*;

  logic [ADDR_BITS-1:0] span_lo  [MAX_INTERVALS];
  logic [END_BITS-1:0]  span_end [MAX_INTERVALS];
  int                   span_count;
  logic [ADDR_BITS-1:0] max_addr;
  out_word_t            due_words [$];
  int                   mismatch_count;

  function automatic bit merge_span(input logic [ADDR_BITS-1:0] lo,
                                    input logic [END_BITS-1:0] fin);
    int                   first;
    int                   last;
    int                   gone;
    logic [ADDR_BITS-1:0] ns;
    logic [END_BITS-1:0]  ne;
    first = 0;
    while (first < span_count && span_end[first] < lo) first++;
    last = first;
    while (last < span_count && span_lo[last] <= fin) last++;
    if (last == first) begin
      if (span_count >= MAX_INTERVALS) return 1'b1;
      for (int i = span_count; i > first; i--) begin
        span_lo[i]  = span_lo[i-1];
        span_end[i] = span_end[i-1];
      end
      span_lo[first]  = lo;
      span_end[first] = fin;
      span_count++;
      return 1'b0;
    end
    ns = (span_lo[first] < lo) ? span_lo[first] : lo;
    ne = (span_end[last-1] > fin) ? span_end[last-1] : fin;
    span_lo[first]  = ns;
    span_end[first] = ne;
    gone = last - first - 1;
    if (gone > 0) begin
      for (int i = last; i < span_count; i++) begin
        span_lo[i-gone]  = span_lo[i];
        span_end[i-gone] = span_end[i];
      end
      span_count -= gone;
    end
    return 1'b0;
  endfunction

  function automatic out_word_t predict_word(input in_word_t w);
    logic [ADDR_BITS-1:0] lo;
    logic [ADDR_BITS-1:0] hi;
    logic [END_BITS-1:0]  limit;
    logic [END_BITS-1:0]  cov;
    logic [END_BITS-1:0]  e;
    out_word_t            r;
    bit                   dropped;
    dropped = 1'b0;
    lo = w.range_low[ADDR_BITS-1:0];
    hi = w.range_high[ADDR_BITS-1:0];
    limit = {1'b0, max_addr} + 1'b1;
    cov = '0;
    if (w.restart) span_count = 0;
    if (hi >= lo) dropped = merge_span(lo, {1'b0, hi} + 1'b1);
    for (int i = 0; i < span_count; i++) begin
      if (span_lo[i] < limit) begin
        e = (span_end[i] < limit) ? span_end[i] : limit;
        cov += e - span_lo[i];
      end
    end
    r = '0;
    if (span_count == 0 || span_lo[0] != '0) begin
      r.lowest_free = '0;
    end else begin
      r.lowest_free = (span_end[0] < limit) ? span_end[0] : limit;
    end
    r.free_count = limit - cov;
    r.table_full = dropped;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input out_word_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: lowest_free/free_count/table_full exp %h %h %b got %h %h %b",
               $realtime, what, want.lowest_free, want.free_count, want.table_full,
               out_word_o.lowest_free, out_word_o.free_count, out_word_o.table_full);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_count     = 0;
      max_addr       = '1;
      mismatch_count = 0;
      due_words.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      out_word_t want;
      if (cfg_we_i) max_addr = cfg_wdata_i[ADDR_BITS-1:0];
      if (result_valid_o) begin
        if (due_words.size() == 0) begin
          note_mismatch("result word with none outstanding", '0);
        end else begin
          want = due_words.pop_front();
          if (out_word_o.lowest_free !== want.lowest_free ||
              out_word_o.free_count !== want.free_count ||
              out_word_o.table_full !== want.table_full) begin
            note_mismatch("result word mismatch", want);
          end
        end
      end
      if (start && !busy) due_words = {due_words, predict_word(in_word_i)};
      pending_o <= due_words.size();
      errors_o  <= mismatch_count;
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import iut_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 292;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  in_word_t              in_word_i   = '0;
  logic                  cfg_we_i    = 1'b0;
  logic [FIELD_BITS-1:0] cfg_wdata_i = '0;
  logic                  busy;
  out_word_t             out_word_o;
  logic                  result_valid_o;

  int          pending_count;
  int          error_count;
  int          cycles = 0;
  int          send_idle = 0;
  logic [31:0] max_addr_now = 32'hFFFF_FFFF;
  logic [31:0] win_base = 32'd0;
  logic [31:0] win_size = 32'd1024;

  interval_union_table_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_word_i      (in_word_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_word_o     (out_word_o),
    .result_valid_o (result_valid_o)
  );

  interval_union_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_word_i      (in_word_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_word_o     (out_word_o),
    .result_valid_o (result_valid_o),
    .pending_o      (pending_count),
    .errors_o       (error_count)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL interval_union_table_top");
      $finish;
    end
  end

  task automatic send_word(input in_word_t w);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_range(input logic rst, input logic [31:0] lo, input logic [31:0] hi);
    in_word_t w;
    w.restart    = rst;
    w.range_low  = lo;
    w.range_high = hi;
    send_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  task automatic write_max(input logic [31:0] v);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= v;
    max_addr_now = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_word_t next_range();
    in_word_t    w;
    logic [31:0] lo;
    logic [31:0] hi;
    int          pick;
    w = '0;
    w.restart = ($urandom_range(99) < 3);
    if (w.restart) begin
      win_size = 32'd64 << $urandom_range(0, 7);
      case ($urandom_range(3))
        0:       win_base = 32'd0;
        1:       win_base = $urandom;
        2:       win_base = 32'hFFFF_FFFF - win_size + 1;
        default: win_base = max_addr_now - (win_size >> 1);
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 5) begin
      // reversed range
      lo = $urandom;
      if (lo == 0) lo = 32'd1;
      hi = $urandom_range(0, lo - 1);
    end else if (pick < 10) begin
      lo = $urandom;
      hi = $urandom;
      if (hi < lo) begin
        lo = hi;
        hi = lo ^ hi ^ lo;
        hi = $urandom_range(lo, 32'hFFFF_FFFF);
      end
    end else if (pick < 40) begin
      // spaced points, fills the table
      lo = win_base + 4 * $urandom_range(0, 99);
      hi = lo + $urandom_range(0, 1);
      if (hi < lo) hi = 32'hFFFF_FFFF;
    end else begin
      lo = win_base + $urandom_range(0, win_size - 1);
      if ($urandom_range(9) == 0) hi = lo + $urandom_range(0, win_size);
      else hi = lo + $urandom_range(0, 15);
      if (hi < lo) hi = 32'hFFFF_FFFF;
    end
    w.range_low  = lo;
    w.range_high = hi;
    return w;
  endfunction

  initial begin
    logic [31:0] max_plan [PHASES];
    int          idle_plan [PHASES];
    max_plan[0] = 32'hFFFF_FFFF; idle_plan[0] = 0;
    max_plan[1] = 32'd0;         idle_plan[1] = 51;
    max_plan[2] = 32'd4095;      idle_plan[2] = 31;
    max_plan[3] = $urandom;      idle_plan[3] = 0;
    max_plan[4] = 32'h7FFF_FFFF; idle_plan[4] = 51;
    max_plan[5] = 32'hFFFF_FFFF; idle_plan[5] = 31;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_range(1'b1, 32'd0, 32'd0);
    send_range(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(1'b0, 32'h8000_0000, 32'h8000_0000);
    send_range(1'b0, 32'd10, 32'd5);
    send_range(1'b0, 32'd2, 32'd3);
    send_range(1'b0, 32'd1, 32'd1);
    send_range(1'b0, 32'd5, 32'd9);
    send_range(1'b0, 32'd20, 32'd30);
    send_range(1'b0, 32'd40, 32'd50);
    send_range(1'b0, 32'd31, 32'd39);
    send_range(1'b0, 32'd15, 32'd60);
    send_range(1'b1, 32'd7, 32'd3);
    send_range(1'b1, 32'd0, 32'hFFFF_FFFF);
    send_range(1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
    send_range(1'b1, 32'hAAAA_AAAA, 32'hFFFF_FFFE);
    send_range(1'b0, 32'h5555_5555, 32'h5555_5555);
    send_range(1'b1, 32'h1234_5678, 32'h1234_5677);
    send_range(1'b0, 32'h1234_5678, 32'h1234_5679);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_max(max_plan[p]);
      send_idle = idle_plan[p];
      repeat (PHASE_WORDS) send_word(next_range());
      drain();
    end

    repeat (80) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS interval_union_table_top");
    end else begin
      $display("FAIL interval_union_table_top");
    end
    $finish;
  end

endmodule

>>> interval_union_table_top.f
rtl/iut_pkg.sv
rtl/iut_ctrl.sv
rtl/iut_datapath.sv
rtl/interval_union_table_top.sv
verif/interval_union_checker.sv
verif/testbench.sv
